// ----- src/astep_pkg.sv -----
package astep_pkg;

   // Register indexes on the configuration port
   localparam logic [3:0] CSR_RISE_THRESHOLD = 4'd0;
   localparam logic [3:0] CSR_FALL_THRESHOLD = 4'd1;
   localparam logic [3:0] CSR_STEP_LENGTH_MM = 4'd2;
   localparam logic [3:0] CSR_GOAL_KM        = 4'd3;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Register widths and reset values
   localparam int THR_W  = 12;
   localparam int LEN_W  = 12;
   localparam int GOAL_W = 8;
   localparam logic [THR_W-1:0]  RISE_RESET = 12'd512;
   localparam logic [THR_W-1:0]  FALL_RESET = 12'd205;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 12'd664;
   localparam logic [GOAL_W-1:0] GOAL_RESET = 8'd0;

   // Result widths
   localparam int STEP_W = 16;
   localparam int DIST_W = 32;

   // Squared magnitude bounds: (16384 + 4095)^2 fits in 29 bits
   localparam int BOUND_SQ_W = 29;

   // Goal in mm: 255 km is below 2^28 mm
   localparam int MM_PER_KM = 1000000;
   localparam int GOAL_MM_W = 28;

   typedef struct packed {
      logic [BOUND_SQ_W-1:0] rise_hi_sq;
      logic [BOUND_SQ_W-1:0] rise_lo_sq;
      logic                  rise_lo_en;
      logic [BOUND_SQ_W-1:0] fall_hi_sq;
      logic [BOUND_SQ_W-1:0] fall_lo_sq;
      logic                  fall_lo_en;
   } bounds_type;

   typedef struct packed {
      logic [LEN_W-1:0]     step_len;
      logic [GOAL_MM_W-1:0] goal_mm;
   } step_cfg_type;

   typedef struct packed {
      logic above_rise;
      logic below_fall;
   } dev_flags_type;

endpackage

// ----- src/astep_if.sv -----
// Input channel: one three-axis sample per item
interface astep_req_if #(parameter int ACCEL_BITS = 14);
   logic                         valid;
   logic                         ready;
   logic signed [ACCEL_BITS-1:0] accel_x;
   logic signed [ACCEL_BITS-1:0] accel_y;
   logic signed [ACCEL_BITS-1:0] accel_z;

   modport source (output valid, accel_x, accel_y, accel_z, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

// Result channel: totals and flags per item
interface astep_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [astep_pkg::STEP_W-1:0]      step_count;
   logic [astep_pkg::DIST_W-1:0]      distance_mm;
   logic                              step_detected;
   logic                              goal_reached;

   modport source (output valid, step_count, distance_mm, step_detected, goal_reached,
                   input ready);
   modport sink   (input valid, step_count, distance_mm, step_detected, goal_reached,
                   output ready);
endinterface

// Register write channel
interface astep_csr_if;
   logic                              valid;
   logic                              ready;
   logic [astep_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [astep_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- src/astep_lane.sv -----
module astep_lane #(
   parameter int ACCEL_BITS = 14
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [ACCEL_BITS-1:0]  axis,
   output logic [2*ACCEL_BITS-2:0]       sq_ff
);

   localparam int SQ_W = 2 * ACCEL_BITS - 1;

   logic signed [2*ACCEL_BITS-1:0] prod;
   logic [SQ_W-1:0]                sq_in;

   // Square of one axis; never negative, top bit is redundant
   always_comb begin
      prod  = axis * axis;
      sq_in = prod[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff <= sq_in;
      end
   end

endmodule

// ----- src/astep_cfg.sv -----
module astep_cfg #(
   parameter int COUNTS_PER_G = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              write_en,
   input  logic [astep_pkg::CSR_INDEX_W-1:0] reg_index,
   input  logic [astep_pkg::CSR_DATA_W-1:0]  wdata,
   output astep_pkg::bounds_type             bounds_ff,
   output astep_pkg::step_cfg_type           step_cfg_ff
);

   // Wide enough for 1 g plus the largest threshold
   localparam int BND_W = $clog2(COUNTS_PER_G + 4096);
   localparam logic [BND_W-1:0] G_VAL = BND_W'(COUNTS_PER_G);

   logic [astep_pkg::THR_W-1:0]  rise_ff;
   logic [astep_pkg::THR_W-1:0]  fall_ff;
   logic [astep_pkg::LEN_W-1:0]  len_ff;
   logic [astep_pkg::GOAL_W-1:0] goal_ff;

   logic [BND_W-1:0]         rise_t, fall_t;
   logic [BND_W-1:0]         rise_hi, rise_lo, fall_hi, fall_lo;
   astep_pkg::bounds_type    bounds_in;
   astep_pkg::step_cfg_type  step_cfg_in;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff <= astep_pkg::RISE_RESET;
         fall_ff <= astep_pkg::FALL_RESET;
         len_ff  <= astep_pkg::LEN_RESET;
         goal_ff <= astep_pkg::GOAL_RESET;
      end else if (write_en) begin
         case (reg_index)
            astep_pkg::CSR_RISE_THRESHOLD: rise_ff <= wdata[astep_pkg::THR_W-1:0];
            astep_pkg::CSR_FALL_THRESHOLD: fall_ff <= wdata[astep_pkg::THR_W-1:0];
            astep_pkg::CSR_STEP_LENGTH_MM: len_ff  <= wdata[astep_pkg::LEN_W-1:0];
            astep_pkg::CSR_GOAL_KM:        goal_ff <= wdata[astep_pkg::GOAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Magnitude window edges, squared; lower edge if rise < 1 g or fall <= 1 g
   always_comb begin
      rise_t  = BND_W'(rise_ff);
      fall_t  = BND_W'(fall_ff);
      rise_hi = G_VAL + rise_t;
      rise_lo = G_VAL - rise_t;
      fall_hi = G_VAL + fall_t;
      fall_lo = G_VAL - fall_t;

      bounds_in.rise_hi_sq = astep_pkg::BOUND_SQ_W'(rise_hi)
                           * astep_pkg::BOUND_SQ_W'(rise_hi);
      bounds_in.rise_lo_sq = astep_pkg::BOUND_SQ_W'(rise_lo)
                           * astep_pkg::BOUND_SQ_W'(rise_lo);
      bounds_in.rise_lo_en = rise_t < G_VAL;
      bounds_in.fall_hi_sq = astep_pkg::BOUND_SQ_W'(fall_hi)
                           * astep_pkg::BOUND_SQ_W'(fall_hi);
      bounds_in.fall_lo_sq = astep_pkg::BOUND_SQ_W'(fall_lo)
                           * astep_pkg::BOUND_SQ_W'(fall_lo);
      bounds_in.fall_lo_en = fall_t <= G_VAL;

      step_cfg_in.step_len = len_ff;
      step_cfg_in.goal_mm  = astep_pkg::GOAL_MM_W'(goal_ff)
                           * astep_pkg::GOAL_MM_W'(astep_pkg::MM_PER_KM);
   end

   // Derived values are registered and follow the registers in the next cycle
   always_ff @(posedge clock) begin
      bounds_ff   <= bounds_in;
      step_cfg_ff <= step_cfg_in;
   end

endmodule

// ----- src/astep_merge.sv -----
module astep_merge #(
   parameter int ACCEL_BITS = 14
) (
   input  logic                            clock,
   input  logic                            load_sum,
   input  logic                            load_flags,
   input  logic [2*ACCEL_BITS-2:0]         sq_x,
   input  logic [2*ACCEL_BITS-2:0]         sq_y,
   input  logic [2*ACCEL_BITS-2:0]         sq_z,
   input  astep_pkg::bounds_type           bounds,
   output astep_pkg::dev_flags_type        flags_ff
);

   localparam int SUM_W = 2 * ACCEL_BITS;
   localparam int CMP_W = (SUM_W > astep_pkg::BOUND_SQ_W) ? SUM_W : astep_pkg::BOUND_SQ_W;

   logic [SUM_W-1:0]          sum_ff;
   logic [SUM_W-1:0]          sum_in;
   logic [CMP_W-1:0]          s, rh, rl, fh, fl;
   astep_pkg::dev_flags_type  flags_in;

   // Squared magnitude from the three lanes
   always_comb begin
      sum_in = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
   end

   always_ff @(posedge clock) begin
      if (load_sum) begin
         sum_ff <= sum_in;
      end
   end

   // Deviation tests against the squared window edges
   always_comb begin
      s  = CMP_W'(sum_ff);
      rh = CMP_W'(bounds.rise_hi_sq);
      rl = CMP_W'(bounds.rise_lo_sq);
      fh = CMP_W'(bounds.fall_hi_sq);
      fl = CMP_W'(bounds.fall_lo_sq);
      flags_in.above_rise = (s > rh) || (bounds.rise_lo_en && (s < rl));
      flags_in.below_fall = (s < fh) && (!bounds.fall_lo_en || (s > fl));
   end

   always_ff @(posedge clock) begin
      if (load_flags) begin
         flags_ff <= flags_in;
      end
   end

endmodule

// ----- src/astep_track.sv -----
module astep_track (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  astep_pkg::dev_flags_type      flags,
   input  astep_pkg::step_cfg_type       step_cfg,
   output logic [astep_pkg::STEP_W-1:0]  step_ff,
   output logic [astep_pkg::DIST_W-1:0]  dist_ff,
   output logic                          detected_ff,
   output logic                          goal_ff,
   output logic                          in_step_ff
);

   logic                          in_step_in;
   logic [astep_pkg::STEP_W-1:0]  step_in;
   logic [astep_pkg::DIST_W-1:0]  dist_in;
   logic                          detected_in;
   logic                          goal_in;
   logic [astep_pkg::STEP_W:0]    step_sum;
   logic [astep_pkg::DIST_W:0]    dist_sum;

   // Hysteresis flag and saturating totals
   always_comb begin
      step_sum    = (astep_pkg::STEP_W + 1)'(step_ff) + (astep_pkg::STEP_W + 1)'(2);
      dist_sum    = (astep_pkg::DIST_W + 1)'(dist_ff)
                  + (astep_pkg::DIST_W + 1)'({step_cfg.step_len, 1'b0});
      in_step_in  = in_step_ff;
      step_in     = step_ff;
      dist_in     = dist_ff;
      detected_in = 1'b0;
      if (!in_step_ff) begin
         if (flags.above_rise) begin
            in_step_in = 1'b1;
         end
      end else if (flags.below_fall) begin
         in_step_in  = 1'b0;
         detected_in = 1'b1;
         step_in     = step_sum[astep_pkg::STEP_W] ? '1 : step_sum[astep_pkg::STEP_W-1:0];
         dist_in     = dist_sum[astep_pkg::DIST_W] ? '1 : dist_sum[astep_pkg::DIST_W-1:0];
      end
      goal_in = dist_in >= astep_pkg::DIST_W'(step_cfg.goal_mm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_step_ff <= 1'b0;
         step_ff    <= '0;
         dist_ff    <= '0;
      end else if (advance) begin
         in_step_ff <= in_step_in;
         step_ff    <= step_in;
         dist_ff    <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         detected_ff <= detected_in;
         goal_ff     <= goal_in;
      end
   end

endmodule

// ----- src/accel_step_counter.sv -----
// Step counter working on three-axis accelerometer samples.
//
// req_chan carries one sample per item (accel_x/y/z, signed counts with
// COUNTS_PER_G counts per g). rsp_chan returns one item per sample: the
// step and distance totals after that sample, whether it closed a step
// pair, and whether the distance goal is met. csr_chan writes the four
// registers (rise/fall threshold, step length, goal) and is always ready;
// write only while no sample is in flight.
//
// Four stages: lane squares, lane merge, window compare, state update into
// the output register. One sample per cycle is sustained while
// rsp_chan.ready stays high. Each stage holds its item while the next
// is full and cannot move, so bubbles close up and input is still taken
// while a finished result waits on rsp_chan.ready; a stall that fills all
// stages drops req_chan.ready.
//
// Reset clears the totals, the step flag and all stage valid bits, and
// restores the register defaults; samples may follow right after.
module accel_step_counter #(
   parameter int ACCEL_BITS   = 14,
   parameter int COUNTS_PER_G = 1024
) (
   input  logic          clock,
   input  logic          reset,
   astep_req_if.sink     req_chan,
   astep_rsp_if.source   rsp_chan,
   astep_csr_if.sink     csr_chan
);

   localparam int SQ_W = 2 * ACCEL_BITS - 1;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;
   logic in_step;

   logic [SQ_W-1:0]             sq_x, sq_y, sq_z;
   astep_pkg::bounds_type       bounds;
   astep_pkg::step_cfg_type     step_cfg;
   astep_pkg::dev_flags_type    flags;

   // Stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en4 = !v4_ff || rsp_chan.ready;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
   end

   assign req_chan.ready = en1;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Registers and squared window edges
   astep_cfg #(.COUNTS_PER_G(COUNTS_PER_G)) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_chan.valid),
      .reg_index   (csr_chan.reg_index),
      .wdata       (csr_chan.wdata),
      .bounds_ff   (bounds),
      .step_cfg_ff (step_cfg)
   );

   // One squaring lane per axis
   astep_lane #(.ACCEL_BITS(ACCEL_BITS)) u_lane_x (
      .clock (clock), .load (en1), .axis (req_chan.accel_x), .sq_ff (sq_x)
   );
   astep_lane #(.ACCEL_BITS(ACCEL_BITS)) u_lane_y (
      .clock (clock), .load (en1), .axis (req_chan.accel_y), .sq_ff (sq_y)
   );
   astep_lane #(.ACCEL_BITS(ACCEL_BITS)) u_lane_z (
      .clock (clock), .load (en1), .axis (req_chan.accel_z), .sq_ff (sq_z)
   );

   // Merge lanes and compare against the window
   astep_merge #(.ACCEL_BITS(ACCEL_BITS)) u_merge (
      .clock      (clock),
      .load_sum   (en2),
      .load_flags (en3),
      .sq_x       (sq_x),
      .sq_y       (sq_y),
      .sq_z       (sq_z),
      .bounds     (bounds),
      .flags_ff   (flags)
   );

   // Step state and output register
   astep_track u_track (
      .clock       (clock),
      .reset       (reset),
      .advance     (en4 && v3_ff),
      .flags       (flags),
      .step_cfg    (step_cfg),
      .step_ff     (rsp_chan.step_count),
      .dist_ff     (rsp_chan.distance_mm),
      .detected_ff (rsp_chan.step_detected),
      .goal_ff     (rsp_chan.goal_reached),
      .in_step_ff  (in_step)
   );

   // A completed step pair always clears the step flag
   a_detect_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.step_detected |-> !in_step)
      else $error("step detected while step flag still set");

   // Steps advance in pairs, so the count is even until it saturates
   a_step_even: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (!rsp_chan.step_count[0] || (&rsp_chan.step_count)))
      else $error("odd step count below saturation");

   // A new result only comes from an item in the compare stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(v3_ff))
      else $error("result appeared without an item in the compare stage");

   // Totals only move when an item enters the output register
   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(en4 && v3_ff) |->
         $stable(rsp_chan.step_count) && $stable(rsp_chan.distance_mm))
      else $error("totals changed without an item");

endmodule
